// File: rtl/core/heartbeat_liveness_table_assert.svh
// assertion macros used by the heartbeat table checker
`ifndef HEARTBEAT_LIVENESS_TABLE_ASSERT_SVH
`define HEARTBEAT_LIVENESS_TABLE_ASSERT_SVH

// concurrent check on clk, disabled while rst_n is low
`define HLT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("heartbeat table check failed");

// implication form of the check above
`define HLT_ASSERT_IMPLY(label, ante, cons) \
  `HLT_ASSERT(label, (ante) |-> (cons))

`endif

// File: rtl/core/hlt_pkg.sv
// types, constants and codes of the heartbeat liveness table
package hlt_pkg;

  // table geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int ID_W   = 31;
  localparam int CODE_W = 8;
  localparam int TIME_W = 32;
  localparam int THR_W  = 16;
  localparam int EV_W   = 3;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFLINE   = 8'd1;
  localparam logic [THR_W-1:0]     THRESHOLD_RST     = 16'd35;
  localparam logic [CODE_W-1:0]    OFFLINE_RST       = 8'd6;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_UPDATED = 3'd1;
  localparam logic [EV_W-1:0] EV_ADDED   = 3'd2;
  localparam logic [EV_W-1:0] EV_FULL    = 3'd3;
  localparam logic [EV_W-1:0] EV_OFFLINE = 3'd4;
  localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd5;

  // one table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] seen;
  } entry_t;

  // memory access request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // configuration register values
  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [CODE_W-1:0] offline_code;
  } cfg_t;

  // one result
  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [IDX_W-1:0] slot;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] live;
    logic             gone;
    logic             last;
  } res_t;

endpackage

// File: rtl/core/hlt_mem.sv
// entry memory: one write port, one registered read port
module hlt_mem (
  input  logic              clk,
  input  hlt_pkg::mem_req_t req,
  output hlt_pkg::entry_t   rdata
);

  hlt_pkg::entry_t mem [hlt_pkg::DEPTH];
  hlt_pkg::entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/hlt_cfg.sv
// configuration registers: idle threshold and offline code
module hlt_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlt_pkg::CFG_DATA_W-1:0] cfg_data,
  output hlt_pkg::cfg_t                  cfg
);

  logic [hlt_pkg::THR_W-1:0]  thr_r;
  logic [hlt_pkg::CODE_W-1:0] off_r;

  assign cfg_ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= hlt_pkg::THRESHOLD_RST;
      off_r <= hlt_pkg::OFFLINE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == hlt_pkg::CFG_IDX_THRESHOLD) begin
        thr_r <= cfg_data[hlt_pkg::THR_W-1:0];
      end
      if (cfg_index == hlt_pkg::CFG_IDX_OFFLINE) begin
        off_r <= cfg_data[hlt_pkg::CODE_W-1:0];
      end
    end
  end

  assign cfg.threshold    = thr_r;
  assign cfg.offline_code = off_r;

endmodule

// File: rtl/core/hlt_seq.sv
// sequencer: lookup, append, refresh and in-place compaction of the table
module hlt_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [hlt_pkg::ID_W-1:0]     in_id,
  input  logic [hlt_pkg::CODE_W-1:0]   in_code,
  input  logic [hlt_pkg::TIME_W-1:0]   in_now,
  input  hlt_pkg::cfg_t                cfg,
  output hlt_pkg::mem_req_t            mem_req,
  input  hlt_pkg::entry_t              mem_q,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hlt_pkg::res_t                out_res
);

  localparam int CW = hlt_pkg::CNT_W;
  localparam int IW = hlt_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic          sweep_r, sweep_nxt;
  logic          shift_r, shift_nxt;
  logic          pend_v_r, pend_v_nxt;
  hlt_pkg::res_t pend_r, pend_nxt;
  logic [hlt_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [hlt_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [hlt_pkg::TIME_W-1:0] now_r, now_nxt;

  logic          out_v_r;
  hlt_pkg::res_t out_r;
  logic          out_free;
  logic          push;
  hlt_pkg::res_t push_res;

  logic [hlt_pkg::TIME_W-1:0] idle;
  logic                       drop;
  logic [CW-1:0]              cnt_dec;

  assign out_free = !out_v_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign idle     = now_r - mem_q.seen;
  assign drop     = sweep_r &&
                    (idle > {{(hlt_pkg::TIME_W-hlt_pkg::THR_W){1'b0}}, cfg.threshold});
  assign cnt_dec  = cnt_r - CW'(1);

  // next-state and datapath control
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    end_nxt    = end_r;
    sweep_nxt  = sweep_r;
    shift_nxt  = shift_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    id_nxt     = id_r;
    code_nxt   = code_r;
    now_nxt    = now_r;
    push       = 1'b0;
    push_res   = pend_r;
    mem_req    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt     = in_id;
          code_nxt   = in_code;
          now_nxt    = in_now;
          sweep_nxt  = in_cmd;
          shift_nxt  = 1'b0;
          rd_nxt     = '0;
          wr_nxt     = '0;
          end_nxt    = cnt_r;
          pend_v_nxt = 1'b0;
          state_nxt  = S_RD;
        end
      end

      S_RD: begin
        if (rd_r == end_r) begin
          if (!sweep_r && !shift_r) begin
            // lookup missed: append or report a full table
            pend_v_nxt = 1'b1;
            pend_nxt.id   = id_r;
            pend_nxt.gone = 1'b0;
            pend_nxt.last = 1'b1;
            if (cnt_r != CW'(hlt_pkg::DEPTH)) begin
              mem_req.we         = 1'b1;
              mem_req.waddr      = cnt_r[IW-1:0];
              mem_req.wdata.id   = id_r;
              mem_req.wdata.seen = now_r;
              cnt_nxt        = cnt_r + CW'(1);
              pend_nxt.ev    = hlt_pkg::EV_ADDED;
              pend_nxt.slot  = cnt_r[IW-1:0];
              pend_nxt.live  = cnt_r + CW'(1);
            end else begin
              pend_nxt.ev    = hlt_pkg::EV_FULL;
              pend_nxt.slot  = '0;
              pend_nxt.live  = cnt_r;
            end
          end
          state_nxt = S_DONE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_r[IW-1:0];
          state_nxt     = S_EV;
        end
      end

      S_EV: begin
        if (!sweep_r && !shift_r) begin
          // lookup compare
          if (mem_q.id == id_r) begin
            pend_v_nxt    = 1'b1;
            pend_nxt.id   = id_r;
            pend_nxt.slot = rd_r[IW-1:0];
            pend_nxt.last = 1'b1;
            if (code_r == cfg.offline_code) begin
              cnt_nxt       = cnt_dec;
              pend_nxt.ev   = hlt_pkg::EV_OFFLINE;
              pend_nxt.live = cnt_dec;
              pend_nxt.gone = (cnt_dec == '0);
              shift_nxt     = 1'b1;
              wr_nxt        = rd_r;
              rd_nxt        = rd_r + CW'(1);
              state_nxt     = S_RD;
            end else begin
              mem_req.we         = 1'b1;
              mem_req.waddr      = rd_r[IW-1:0];
              mem_req.wdata.id   = id_r;
              mem_req.wdata.seen = now_r;
              pend_nxt.ev        = hlt_pkg::EV_UPDATED;
              pend_nxt.live      = cnt_r;
              pend_nxt.gone      = 1'b0;
              state_nxt          = S_DONE;
            end
          end else begin
            rd_nxt    = rd_r + CW'(1);
            state_nxt = S_RD;
          end
        end else if (drop) begin
          // timed-out entry: release the previous result, hold this one
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              push          = 1'b1;
              push_res      = pend_r;
              push_res.last = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_nxt.ev   = hlt_pkg::EV_TIMEOUT;
            pend_nxt.slot = wr_r[IW-1:0];
            pend_nxt.id   = mem_q.id;
            pend_nxt.live = cnt_dec;
            pend_nxt.gone = (cnt_dec == '0);
            pend_nxt.last = 1'b1;
            cnt_nxt       = cnt_dec;
            rd_nxt        = rd_r + CW'(1);
            state_nxt     = S_RD;
          end
        end else begin
          // kept entry moves down to the write pointer
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_r[IW-1:0];
          mem_req.wdata = mem_q;
          wr_nxt        = wr_r + CW'(1);
          rd_nxt        = rd_r + CW'(1);
          state_nxt     = S_RD;
        end
      end

      S_DONE: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_v_r) begin
            push_res      = pend_r;
            push_res.last = 1'b1;
          end else begin
            push_res.ev   = hlt_pkg::EV_NONE;
            push_res.slot = '0;
            push_res.id   = '0;
            push_res.live = cnt_r;
            push_res.gone = 1'b0;
            push_res.last = 1'b1;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      if (push) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_r    <= rd_nxt;
    wr_r    <= wr_nxt;
    end_r   <= end_nxt;
    sweep_r <= sweep_nxt;
    shift_r <= shift_nxt;
    pend_r  <= pend_nxt;
    id_r    <= id_nxt;
    code_r  <= code_nxt;
    now_r   <= now_nxt;
    if (push) begin
      out_r <= push_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

// File: rtl/core/heartbeat_liveness_table.sv
// top level of the heartbeat liveness table
// The table of up to 16 live machines sits in one entry memory with a
// registered read. A status transaction scans the entries in order,
// visiting each with a read state and then a compare state. The scan
// stops at a matching entry; a new id is compared against all entries
// present before it is appended or the table is reported full. An
// offline code removes the matched entry and the later entries move
// down. A sweep transaction walks all entries present once, compacting
// survivors in place; each removal yields one result, and a result
// waits only if the previous one has not been taken. The final result
// reaches the output register in the same cycle that the block becomes
// ready again. Input is taken only when the block is idle; the final
// result sits in an output register while the next transaction is
// accepted. Configuration writes are always accepted and must be made
// while no transaction is in progress.
module heartbeat_liveness_table (
  input  logic                           clk,
  input  logic                           rst_n,
  // input transaction
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [30:0] machine_id, [38:31] status_code, [70:39] now, [71] zero
  input  logic [71:0]                    in_tdata,
  // [0] command
  input  logic [0:0]                     in_tuser,
  // result transaction
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [3:0] slot, [34:4] reported_id, [39:35] live_count, [40] all_gone,
  // [47:41] zero
  output logic [47:0]                    out_tdata,
  // [2:0] event_res
  output logic [2:0]                     out_tuser,
  output logic                           out_tlast,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlt_pkg::CFG_DATA_W-1:0] cfg_data
);

  hlt_pkg::cfg_t     cfg;
  hlt_pkg::mem_req_t mem_req;
  hlt_pkg::entry_t   mem_q;
  hlt_pkg::res_t     res;

  hlt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hlt_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_q)
  );

  hlt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser[0]),
    .in_id     (in_tdata[30:0]),
    .in_code   (in_tdata[38:31]),
    .in_now    (in_tdata[70:39]),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_q     (mem_q),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // result packing
  assign out_tdata = {7'd0, res.gone, res.live, res.id, res.slot};
  assign out_tuser = res.ev;
  assign out_tlast = res.last;

endmodule

// File: rtl/core/hlt_checker.sv
// port-level checks of the heartbeat liveness table, bound to the top level
`include "heartbeat_liveness_table_assert.svh"

module hlt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  logic [51:0]                out_beat;
  logic [hlt_pkg::CNT_W-1:0]  out_live;
  logic                       out_gone;
  logic                       out_timeout;
  logic                       out_removal;

  // result fields as seen on the bus
  assign out_beat    = {out_tlast, out_tuser, out_tdata};
  assign out_live    = out_tdata[39:35];
  assign out_gone    = out_tdata[40];
  assign out_timeout = (out_tuser == hlt_pkg::EV_TIMEOUT);
  assign out_removal = out_timeout || (out_tuser == hlt_pkg::EV_OFFLINE);

  // a stalled result holds still
  `HLT_ASSERT_IMPLY(a_out_hold, out_tvalid && !out_tready, ##1 (out_tvalid && $stable(out_beat)))

  // all_gone only on a removal that leaves no entry
  `HLT_ASSERT_IMPLY(a_gone_removal, out_tvalid && out_gone, out_removal && out_live == '0)

  // live count never above the table size
  `HLT_ASSERT_IMPLY(a_live_range, out_tvalid, out_live <= 5'd16)

  // no new input while a sweep still has results to deliver
  `HLT_ASSERT_IMPLY(a_busy_in_sweep, out_tvalid && !out_tlast, !in_tready && out_timeout)

endmodule

bind heartbeat_liveness_table hlt_checker u_hlt_checker (.*);

// File: tb/heartbeat_liveness_table_tb.sv
// testbench for the heartbeat liveness table: directed, random and backpressure runs
`timescale 1ns / 1ps

module heartbeat_liveness_table_tb;
  import hlt_pkg::*;

  localparam logic CMD_STATUS = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFE;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 10;
  localparam int POOL_SIZE = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [71:0]           in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [47:0]           out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  heartbeat_liveness_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow copy of the liveness table and its registers
  logic [ID_W-1:0]   table_ids  [DEPTH];
  logic [TIME_W-1:0] table_seen [DEPTH];
  int                table_count;
  logic [THR_W-1:0]  threshold_shadow;
  logic [CODE_W-1:0] offline_shadow;

  res_t        pending_events [$];
  int          error_count;
  int          items_sent;
  int          event_tally [6];
  int          send_gap_pct;
  int          recv_stall_pct;
  int          hold_request;
  logic [TIME_W-1:0] wall_sec;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // remove one entry and close the gap
  task automatic drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < table_count; i++) begin
      table_ids[i]  = table_ids[i + 1];
      table_seen[i] = table_seen[i + 1];
    end
    table_count--;
  endtask

  // work out the events one transaction causes and queue them
  task automatic apply_heartbeat(input logic cmd, input logic [ID_W-1:0] mid,
                                 input logic [CODE_W-1:0] code,
                                 input logic [TIME_W-1:0] t);
    res_t r;
    int i;
    int pos;
    int removed;
    logic [TIME_W-1:0] idle;
    logic [ID_W-1:0] gone_id;
    r = '0;
    if (cmd == CMD_STATUS) begin
      pos = -1;
      for (i = 0; i < table_count; i++)
        if (pos < 0 && table_ids[i] == mid) pos = i;
      r.id = mid;
      r.last = 1'b1;
      if (pos >= 0) begin
        table_seen[pos] = t;
        r.slot = IDX_W'(pos);
        if (code == offline_shadow) begin
          drop_slot(pos);
          r.ev = EV_OFFLINE;
          r.gone = (table_count == 0);
        end else begin
          r.ev = EV_UPDATED;
        end
      end else if (table_count < DEPTH) begin
        table_ids[table_count]  = mid;
        table_seen[table_count] = t;
        r.slot = IDX_W'(table_count);
        r.ev = EV_ADDED;
        table_count++;
      end else begin
        r.ev = EV_FULL;
      end
      r.live = CNT_W'(table_count);
      pending_events.push_back(r);
    end else begin
      // sweep in table order, position stays put after a removal
      removed = 0;
      i = 0;
      while (i < table_count) begin
        idle = t - table_seen[i];
        if (idle > TIME_W'(threshold_shadow)) begin
          gone_id = table_ids[i];
          drop_slot(i);
          r.ev   = EV_TIMEOUT;
          r.slot = IDX_W'(i);
          r.id   = gone_id;
          r.live = CNT_W'(table_count);
          r.gone = (table_count == 0);
          r.last = 1'b0;
          pending_events.push_back(r);
          removed++;
        end else begin
          i++;
        end
      end
      if (removed == 0) begin
        r.ev   = EV_NONE;
        r.live = CNT_W'(table_count);
        r.last = 1'b1;
        pending_events.push_back(r);
      end else begin
        pending_events[$].last = 1'b1;
      end
    end
  endtask

  // offer one transaction; tvalid stays high until the next call or a wait
  task automatic send_item(input logic cmd, input logic [ID_W-1:0] mid,
                           input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, t, code, mid};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_heartbeat(cmd, mid, code, t);
    items_sent++;
  endtask

  // drain all expected events, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers plus one unmapped index, block idle
  task automatic set_config(input logic [THR_W-1:0] thr, input logic [CFG_DATA_W-1:0] code_word);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    threshold_shadow = thr;
    cfg_index <= CFG_IDX_OFFLINE;
    cfg_data  <= code_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    offline_shadow = code_word[CODE_W-1:0];
    cfg_index <= CFG_IDX_UNUSED;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reset values: updates, offline removal, threshold boundary, table empties
  task automatic test_defaults_and_updates();
    send_item(CMD_SWEEP,  '0,           8'h00, 32'd0);
    send_item(CMD_STATUS, '0,           8'hFF, 32'd0);
    send_item(CMD_STATUS, 31'h7FFFFFFF, 8'd6,  32'd10);
    send_item(CMD_STATUS, '0,           8'h00, 32'd20);
    send_item(CMD_SWEEP,  31'h7FFFFFFF, 8'hFF, 32'd45);
    send_item(CMD_STATUS, 31'h7FFFFFFF, 8'd6,  32'd46);
    send_item(CMD_SWEEP,  '0,           8'h00, 32'd56);
    wall_sec = 32'd56;
  endtask

  // fill just below the time wrap, list full, then timeouts down to empty
  task automatic test_fill_wrap_and_full();
    logic [ID_W-1:0] fill_ids [DEPTH];
    int k;
    wall_sec = 32'hFFFF_FFF0;
    for (k = 0; k < DEPTH; k++) begin
      fill_ids[k] = (ID_W'($urandom) & 31'h7FFF_FFF0) | ID_W'(k);
      send_item(CMD_STATUS, fill_ids[k], CODE_W'(k * 16 + 1), wall_sec + TIME_W'(k));
    end
    send_item(CMD_STATUS, '0, 8'h80, 32'd0);
    send_item(CMD_STATUS, fill_ids[DEPTH-1], 8'h01, 32'd2);
    send_item(CMD_SWEEP, '0, 8'h00, 32'd37);
    send_item(CMD_SWEEP, '0, 8'h00, 32'd38);
    wall_sec = 32'd38;
  endtask

  // random status and sweep traffic under one setting and idling mix
  task automatic test_random_phase(input int gap_pct, input int stall_pct,
                                   input logic [THR_W-1:0] thr,
                                   input logic [CFG_DATA_W-1:0] code_word, input int count);
    logic [ID_W-1:0] pool [POOL_SIZE];
    logic [ID_W-1:0] mid;
    logic [CODE_W-1:0] code;
    int k;
    int roll;
    set_config(thr, code_word);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < POOL_SIZE; k++) pool[k] = ID_W'($urandom);
    pool[0] = '0;
    pool[1] = 31'h7FFFFFFF;
    for (k = 0; k < count; k++) begin
      // mostly small steps, some past the threshold, rarely anywhere
      roll = $urandom_range(99);
      if (roll < 3) wall_sec = $urandom;
      else if (roll < 12) wall_sec += TIME_W'(thr) + $urandom_range(1, 4);
      else wall_sec += $urandom_range(0, thr / 4 + 2);
      if ($urandom_range(99) < 18) begin
        send_item(CMD_SWEEP, ID_W'($urandom), CODE_W'($urandom), wall_sec);
      end else begin
        mid  = ($urandom_range(99) < 6) ? ID_W'($urandom) : pool[$urandom_range(POOL_SIZE - 1)];
        code = ($urandom_range(99) < 22) ? offline_shadow : CODE_W'($urandom_range(255));
        send_item(CMD_STATUS, mid, code, wall_sec);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    int k;
    wait_idle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_request   = 300;
    for (k = 0; k < 12; k++) begin
      wall_sec += 1;
      if (k % 4 == 3) send_item(CMD_SWEEP, '0, 8'h00, wall_sec);
      else send_item(CMD_STATUS, ID_W'($urandom_range(0, 20)), 8'h00, wall_sec);
    end
  endtask

  // result receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare one field of a result
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser < 6) event_tally[out_tuser]++;
      if (pending_events.size() == 0) begin
        $error("unexpected result event_res %0d reported_id %0h", out_tuser, out_tdata[34:4]);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res",   32'(want.ev),   32'(out_tuser));
        check_field("slot",        32'(want.slot), 32'(out_tdata[3:0]));
        check_field("reported_id", 32'(want.id),   32'(out_tdata[34:4]));
        check_field("live_count",  32'(want.live), 32'(out_tdata[39:35]));
        check_field("all_gone",    32'(want.gone), 32'(out_tdata[40]));
        check_field("last",        32'(want.last), 32'(out_tlast));
      end
    end
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", pending_events.size());
    $display("*** FAILED ***");
    $finish;
  end

  // test sequence
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    table_count      = 0;
    threshold_shadow = THRESHOLD_RST;
    offline_shadow   = OFFLINE_RST;
    error_count    = 0;
    items_sent     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    wall_sec       = '0;
    foreach (event_tally[k]) event_tally[k] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults_and_updates();
    test_fill_wrap_and_full();
    test_random_phase(0,  0,  16'd0,                          16'hA500, 38);
    test_random_phase(49, 0,  16'hFFFF,                       16'h5AFF, 38);
    test_random_phase(0,  49, THR_W'($urandom_range(5, 60)),
                      CFG_DATA_W'($urandom), 38);
    test_random_phase(28, 28, THRESHOLD_RST,                  {8'h00, OFFLINE_RST}, 38);
    test_output_backpressure();
    wait_idle();

    if (pending_events.size() != 0) begin
      $error("%0d expected results never arrived", pending_events.size());
      error_count++;
    end
    $display("%0d transactions sent; events seen: none %0d, updated %0d, added %0d, full %0d,",
             items_sent, event_tally[0], event_tally[1], event_tally[2], event_tally[3]);
    $display("offline %0d, timeout %0d; threshold and offline code swept to both extremes",
             event_tally[4], event_tally[5]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/hlt_pkg.sv
rtl/core/hlt_mem.sv
rtl/core/hlt_cfg.sv
rtl/core/hlt_seq.sv
rtl/core/heartbeat_liveness_table.sv
rtl/core/hlt_checker.sv
tb/heartbeat_liveness_table_tb.sv
